/* rtl/ttc_pkg.sv */
`timescale 1ns / 1ps

package ttc_pkg;

    // field and datapath widths
    localparam int VOLT_W = 15;
    localparam int RES_W  = 24;
    localparam int TEMP_W = 16;
    localparam int PROD_W = 35;
    localparam int TOP_W  = 6;
    localparam int MANT_W = 32;
    localparam int FRAC_W = 24;
    localparam int LOG_W  = TOP_W + FRAC_W;
    localparam int RN_W   = 36;
    localparam int DEN_W  = 48;
    localparam int NUM_W  = 63;
    localparam int TQ_W   = 17;

    // constants of the conversion
    localparam logic [29:0] LN2_Q30      = 30'd744261118;
    localparam int          KELVIN_CENTI = 27315;

    // configuration register indexes
    localparam logic [2:0] CFG_SUPPLY   = 3'd0;
    localparam logic [2:0] CFG_SERIES   = 3'd1;
    localparam logic [2:0] CFG_REF_TEMP = 3'd2;
    localparam logic [2:0] CFG_REF_OHMS = 3'd3;
    localparam logic [2:0] CFG_BETA     = 3'd4;

    // reset values of the configuration
    localparam logic [14:0] RST_SUPPLY   = 15'd5144;
    localparam logic [19:0] RST_SERIES   = 20'd3000;
    localparam logic [8:0]  RST_REF_TEMP = 9'd20;
    localparam logic [19:0] RST_REF_OHMS = 20'd12110;
    localparam logic [16:0] RST_BETA     = 17'd34205;

    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_HIGH = 2'd1,
        STAT_ZERO = 2'd2
    } t_status;

    // values riding along the resistance divider
    typedef struct packed {
        logic [TOP_W-1:0]  top_b;
        logic [TOP_W-1:0]  top_a;
        logic              rsat;
        logic [VOLT_W-1:0] volt;
        t_status           stat;
    } t_res_pass;

    // values riding along the temperature divider
    typedef struct packed {
        logic [RES_W-1:0]  res;
        logic              tsat;
        logic              nonpos;
        logic [VOLT_W-1:0] volt;
        t_status           stat;
    } t_tmp_pass;

endpackage

/* rtl/thermistor_temperature_convert.sv */
`timescale 1ns / 1ps
// throughput: one word per cycle while skid is empty, pipelined squaring and divider cells
// two 24-cell log chains, a 24-cell resistance divider and a 17-cell temperature divider
// a two-entry output skid keeps input ready high while one result waits
// reset (synchronous, active low) clears all valid bits and loads the default configuration
module thermistor_temperature_convert (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // bus_word
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // voltage_mv, resistance_ohms, temp_centi, zero pad
    output logic [1:0]  o_m_axis_tuser,   // status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [19:0] i_cfg_data
);

    localparam int NSTG   = 51;
    localparam int NLOG   = ttc_pkg::FRAC_W;
    localparam int NRES   = ttc_pkg::RES_W;
    localparam int NTMP   = ttc_pkg::TQ_W;
    localparam int RPW    = $bits(ttc_pkg::t_res_pass);
    localparam int TPW    = $bits(ttc_pkg::t_tmp_pass);

    // configuration registers
    logic [14:0] r_supply;
    logic [19:0] r_series;
    logic [8:0]  r_ref_temp;
    logic [19:0] r_ref_ohms;
    logic [16:0] r_beta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply   <= ttc_pkg::RST_SUPPLY;
            r_series   <= ttc_pkg::RST_SERIES;
            r_ref_temp <= ttc_pkg::RST_REF_TEMP;
            r_ref_ohms <= ttc_pkg::RST_REF_OHMS;
            r_beta     <= ttc_pkg::RST_BETA;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                ttc_pkg::CFG_SUPPLY:   r_supply   <= i_cfg_data[14:0];
                ttc_pkg::CFG_SERIES:   r_series   <= i_cfg_data;
                ttc_pkg::CFG_REF_TEMP: r_ref_temp <= i_cfg_data[8:0];
                ttc_pkg::CFG_REF_OHMS: r_ref_ohms <= i_cfg_data;
                ttc_pkg::CFG_BETA:     r_beta     <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // derived constants of the beta equation
    logic signed [17:0] w_t0c;
    logic [20:0]        w_bt10;

    assign w_t0c  = 18'($signed(r_ref_temp)) * 18'sd100 + 18'sd27315;
    assign w_bt10 = 21'(r_beta) * 21'd10;

    // pipeline advance and valid line
    logic            w_en;
    logic [NSTG-1:0] r_vld;
    logic            r_skid_vld;

    assign w_en            = !r_skid_vld;
    assign o_s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_s_axis_tvalid};
        end
    end

    function automatic logic [ttc_pkg::TOP_W-1:0] f_top(input logic [ttc_pkg::PROD_W-1:0] x);
        logic [ttc_pkg::TOP_W-1:0] top;
        top = '0;
        for (int i = 0; i < ttc_pkg::PROD_W; i++) begin
            if (x[i]) begin
                top = ttc_pkg::TOP_W'(i);
            end
        end
        return top;
    endfunction

    function automatic logic [ttc_pkg::MANT_W-1:0] f_norm(input logic [ttc_pkg::PROD_W-1:0] x,
                                                           input logic [ttc_pkg::TOP_W-1:0] top);
        logic [ttc_pkg::PROD_W-1:0] s;
        if (top > 6'd31) begin
            s = x >> (top - 6'd31);
        end else begin
            s = x << (6'd31 - top);
        end
        return s[ttc_pkg::MANT_W-1:0];
    endfunction

    // stage 1: voltage from the raw word
    logic [14:0] r1_v;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_v <= {i_s_axis_tdata[15:3], 2'b00};
        end
    end

    // stage 2: status, headroom and the two log arguments
    logic [14:0]              w2_d;
    logic [19:0]              w2_s1;
    logic [19:0]              w2_r1;
    ttc_pkg::t_status         w2_stat;
    logic [34:0]              r2_a;
    logic [34:0]              r2_b;
    logic [14:0]              r2_d;
    logic [14:0]              r2_v;
    ttc_pkg::t_status         r2_stat;

    always_comb begin
        w2_d  = r_supply - r1_v;
        w2_s1 = (r_series == 20'd0) ? 20'd1 : r_series;
        w2_r1 = (r_ref_ohms == 20'd0) ? 20'd1 : r_ref_ohms;
        if (r1_v >= r_supply) begin
            w2_stat = ttc_pkg::STAT_HIGH;
        end else if (r1_v == 15'd0) begin
            w2_stat = ttc_pkg::STAT_ZERO;
        end else begin
            w2_stat = ttc_pkg::STAT_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_a    <= 35'(r1_v) * 35'(w2_s1);
            r2_b    <= 35'(w2_d) * 35'(w2_r1);
            r2_d    <= w2_d;
            r2_v    <= r1_v;
            r2_stat <= w2_stat;
        end
    end

    // stage 3: resistance dividend and leading one positions
    logic [35:0]      r3_rn;
    logic [5:0]       r3_top_a;
    logic [5:0]       r3_top_b;
    logic [34:0]      r3_a;
    logic [34:0]      r3_b;
    logic [14:0]      r3_d;
    logic [14:0]      r3_v;
    ttc_pkg::t_status r3_stat;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_rn    <= ((r_series == 20'd0) ? 36'd0 : 36'(r2_a)) + 36'(r2_d >> 1);
            r3_top_a <= f_top(r2_a);
            r3_top_b <= f_top(r2_b);
            r3_a     <= r2_a;
            r3_b     <= r2_b;
            r3_d     <= r2_d;
            r3_v     <= r2_v;
            r3_stat  <= r2_stat;
        end
    end

    // stage 4: normalized mantissas and resistance overflow check
    logic [31:0]        r4_ma;
    logic [31:0]        r4_mb;
    logic [35:0]        r4_rn;
    logic [14:0]        r4_d;
    ttc_pkg::t_res_pass r4_pass;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_ma        <= f_norm(r3_a, r3_top_a);
            r4_mb        <= f_norm(r3_b, r3_top_b);
            r4_rn        <= r3_rn;
            r4_d         <= r3_d;
            r4_pass.top_a <= r3_top_a;
            r4_pass.top_b <= r3_top_b;
            r4_pass.rsat <= (40'(r3_rn) >= (40'(r3_d) << 24));
            r4_pass.volt <= r3_v;
            r4_pass.stat <= r3_stat;
        end
    end

    // log chains: one squaring cell per fraction bit
    logic [31:0] w_lma [0:NLOG];
    logic [23:0] w_lfa [0:NLOG];
    logic [31:0] w_lmb [0:NLOG];
    logic [23:0] w_lfb [0:NLOG];

    assign w_lma[0] = r4_ma;
    assign w_lfa[0] = '0;
    assign w_lmb[0] = r4_mb;
    assign w_lfb[0] = '0;

    // resistance divider: one cell per quotient bit
    logic [35:0]        w_rrem  [0:NRES];
    logic [23:0]        w_rquo  [0:NRES];
    logic [14:0]        w_rden  [0:NRES];
    ttc_pkg::t_res_pass w_rpass [0:NRES];

    assign w_rrem[0]  = r4_rn;
    assign w_rquo[0]  = '0;
    assign w_rden[0]  = r4_d;
    assign w_rpass[0] = r4_pass;

    for (genvar g = 0; g < NLOG; g++) begin : g_log
        ttc_log_cell u_cell_a (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_mant (w_lma[g]),
            .i_frac (w_lfa[g]),
            .o_mant (w_lma[g+1]),
            .o_frac (w_lfa[g+1])
        );
        ttc_log_cell u_cell_b (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_mant (w_lmb[g]),
            .i_frac (w_lfb[g]),
            .o_mant (w_lmb[g+1]),
            .o_frac (w_lfb[g+1])
        );
    end

    for (genvar g = 0; g < NRES; g++) begin : g_res
        ttc_div_cell #(
            .NW  (36),
            .DW  (15),
            .QW  (24),
            .BIT (NRES - 1 - g),
            .PW  (RPW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_rrem[g]),
            .i_quo  (w_rquo[g]),
            .i_den  (w_rden[g]),
            .i_pass (w_rpass[g]),
            .o_rem  (w_rrem[g+1]),
            .o_quo  (w_rquo[g+1]),
            .o_den  (w_rden[g+1]),
            .o_pass (w_rpass[g+1])
        );
    end

    // stage 29: log difference and saturated resistance
    logic [29:0]      w29_la;
    logic [29:0]      w29_lb;
    logic [29:0]      r29_mag;
    logic             r29_neg;
    logic [23:0]      r29_res;
    logic [14:0]      r29_v;
    ttc_pkg::t_status r29_stat;

    assign w29_la = {w_rpass[NRES].top_a, w_lfa[NLOG]};
    assign w29_lb = {w_rpass[NRES].top_b, w_lfb[NLOG]};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r29_mag  <= (w29_la >= w29_lb) ? (w29_la - w29_lb) : (w29_lb - w29_la);
            r29_neg  <= (w29_la < w29_lb);
            r29_res  <= w_rpass[NRES].rsat ? '1 : w_rquo[NRES];
            r29_v    <= w_rpass[NRES].volt;
            r29_stat <= w_rpass[NRES].stat;
        end
    end

    // stage 30: natural log magnitude, rounded
    logic [59:0]      w30_prod;
    logic [29:0]      r30_mag;
    logic             r30_neg;
    logic [23:0]      r30_res;
    logic [14:0]      r30_v;
    ttc_pkg::t_status r30_stat;

    assign w30_prod = 60'(r29_mag) * 60'(ttc_pkg::LN2_Q30) + (60'(1) << 29);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r30_mag  <= w30_prod[59:30];
            r30_neg  <= r29_neg;
            r30_res  <= r29_res;
            r30_v    <= r29_v;
            r30_stat <= r29_stat;
        end
    end

    // stage 31: log term times reference temperature, and the numerator constant
    logic signed [30:0] w31_lq;
    logic signed [48:0] w31_prod;
    logic signed [47:0] r31_p;
    logic [37:0]        r31_numk;
    logic [23:0]        r31_res;
    logic [14:0]        r31_v;
    ttc_pkg::t_status   r31_stat;

    always_comb begin
        w31_lq   = r30_neg ? -$signed({1'b0, r30_mag}) : $signed({1'b0, r30_mag});
        w31_prod = 49'(w31_lq) * 49'(w_t0c);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r31_p    <= 48'(w31_prod);
            r31_numk <= 38'(w_bt10) * 38'(w_t0c[16:0]);
            r31_res  <= r30_res;
            r31_v    <= r30_v;
            r31_stat <= r30_stat;
        end
    end

    // stage 32: beta denominator
    logic signed [47:0] r32_den;
    logic [37:0]        r32_numk;
    logic [23:0]        r32_res;
    logic [14:0]        r32_v;
    ttc_pkg::t_status   r32_stat;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r32_den  <= r31_p + $signed({3'b000, w_bt10, 24'd0});
            r32_numk <= r31_numk;
            r32_res  <= r31_res;
            r32_v    <= r31_v;
            r32_stat <= r31_stat;
        end
    end

    // stage 33: rounded dividend and sign of the denominator
    logic [62:0]      r33_n;
    logic [47:0]      r33_d;
    logic             r33_nonpos;
    logic [23:0]      r33_res;
    logic [14:0]      r33_v;
    ttc_pkg::t_status r33_stat;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r33_n      <= 63'({r32_numk, 24'd0}) + 63'(r32_den[47:1]);
            r33_d      <= r32_den[47:0];
            r33_nonpos <= r32_den[47] || (r32_den == 48'sd0);
            r33_res    <= r32_res;
            r33_v      <= r32_v;
            r33_stat   <= r32_stat;
        end
    end

    // stage 34: quotient overflow check
    logic [62:0]        r34_n;
    logic [47:0]        r34_d;
    ttc_pkg::t_tmp_pass r34_pass;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r34_n           <= r33_n;
            r34_d           <= r33_d;
            r34_pass.tsat   <= (65'(r33_n) >= (65'(r33_d) << ttc_pkg::TQ_W));
            r34_pass.nonpos <= r33_nonpos;
            r34_pass.res    <= r33_res;
            r34_pass.volt   <= r33_v;
            r34_pass.stat   <= r33_stat;
        end
    end

    // temperature divider: one cell per quotient bit
    logic [62:0]        w_trem  [0:NTMP];
    logic [16:0]        w_tquo  [0:NTMP];
    logic [47:0]        w_tden  [0:NTMP];
    ttc_pkg::t_tmp_pass w_tpass [0:NTMP];

    assign w_trem[0]  = r34_n;
    assign w_tquo[0]  = '0;
    assign w_tden[0]  = r34_d;
    assign w_tpass[0] = r34_pass;

    for (genvar g = 0; g < NTMP; g++) begin : g_tmp
        ttc_div_cell #(
            .NW  (63),
            .DW  (48),
            .QW  (17),
            .BIT (NTMP - 1 - g),
            .PW  (TPW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_trem[g]),
            .i_quo  (w_tquo[g]),
            .i_den  (w_tden[g]),
            .i_pass (w_tpass[g]),
            .o_rem  (w_trem[g+1]),
            .o_quo  (w_tquo[g+1]),
            .o_den  (w_tden[g+1]),
            .o_pass (w_tpass[g+1])
        );
    end

    // final: kelvin to celsius, saturation and status masking
    ttc_pkg::t_tmp_pass w_fp;
    logic signed [17:0] w_tk;
    logic [15:0]        w_temp;
    logic [23:0]        w_res;
    logic [55:0]        w_data;

    always_comb begin
        w_fp = w_tpass[NTMP];
        w_tk = $signed({1'b0, w_tquo[NTMP]}) - 18'sd27315;
        if (w_fp.nonpos || w_fp.tsat || (w_tk > 18'sd32767)) begin
            w_temp = 16'h7FFF;
        end else begin
            w_temp = w_tk[15:0];
        end
        w_res = w_fp.res;
        if (w_fp.stat != ttc_pkg::STAT_OK) begin
            w_temp = '0;
            w_res  = '0;
        end
        w_data = {1'b0, w_temp, w_res, w_fp.volt};
    end

    // output register and skid entry
    logic        w_push;
    logic        w_pop;
    logic        r_out_vld;
    logic [55:0] r_out_data;
    logic [1:0]  r_out_user;
    logic [55:0] r_skid_data;
    logic [1:0]  r_skid_user;

    assign w_push = w_en && r_vld[NSTG-1];
    assign w_pop  = r_out_vld && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (w_pop) begin
                r_skid_vld <= 1'b0;
            end
        end else if (w_push) begin
            if (!r_out_vld || w_pop) begin
                r_out_vld <= 1'b1;
            end else begin
                r_skid_vld <= 1'b1;
            end
        end else if (w_pop) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (w_pop) begin
                r_out_data <= r_skid_data;
                r_out_user <= r_skid_user;
            end
        end else if (w_push) begin
            if (!r_out_vld || w_pop) begin
                r_out_data <= w_data;
                r_out_user <= w_fp.stat;
            end else begin
                r_skid_data <= w_data;
                r_skid_user <= w_fp.stat;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // skid entry only holds a word behind a held output word
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word without output word");

    // skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_m_axis_tready))
        else $error("skid filled without a stall");

    // error words carry no resistance or temperature
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser != 2'(ttc_pkg::STAT_OK)))
        |-> (o_m_axis_tdata[54:15] == 40'd0))
        else $error("error word with nonzero result");

    // zero-voltage status goes with a zero voltage
    a_zero_volt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tuser == 2'(ttc_pkg::STAT_ZERO)))
        |-> (o_m_axis_tdata[14:0] == 15'd0))
        else $error("zero status with nonzero voltage");

endmodule

/* rtl/ttc_log_cell.sv */
`timescale 1ns / 1ps

module ttc_log_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [ttc_pkg::MANT_W-1:0]    i_mant,
    input  logic [ttc_pkg::FRAC_W-1:0]    i_frac,
    output logic [ttc_pkg::MANT_W-1:0]    o_mant,
    output logic [ttc_pkg::FRAC_W-1:0]    o_frac
);

    logic [2*ttc_pkg::MANT_W-1:0] w_sq;
    logic [ttc_pkg::MANT_W:0]     w_sh;
    logic [ttc_pkg::MANT_W-1:0]   n_mant;
    logic [ttc_pkg::FRAC_W-1:0]   n_frac;
    logic [ttc_pkg::MANT_W-1:0]   r_mant;
    logic [ttc_pkg::FRAC_W-1:0]   r_frac;

    // square the mantissa, one fraction bit falls out of the overflow
    always_comb begin
        w_sq = (2*ttc_pkg::MANT_W)'(i_mant) * (2*ttc_pkg::MANT_W)'(i_mant);
        w_sh = w_sq[2*ttc_pkg::MANT_W-1:ttc_pkg::MANT_W-1];
        if (w_sh[ttc_pkg::MANT_W]) begin
            n_mant = w_sh[ttc_pkg::MANT_W:1];
            n_frac = {i_frac[ttc_pkg::FRAC_W-2:0], 1'b1};
        end else begin
            n_mant = w_sh[ttc_pkg::MANT_W-1:0];
            n_frac = {i_frac[ttc_pkg::FRAC_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mant <= n_mant;
            r_frac <= n_frac;
        end
    end

    assign o_mant = r_mant;
    assign o_frac = r_frac;

endmodule

/* rtl/ttc_div_cell.sv */
`timescale 1ns / 1ps

module ttc_div_cell #(
    parameter int NW  = 36,
    parameter int DW  = 15,
    parameter int QW  = 24,
    parameter int BIT = 0,
    parameter int PW  = 1
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_rem,
    input  logic [QW-1:0] i_quo,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pass,
    output logic [NW-1:0] o_rem,
    output logic [QW-1:0] o_quo,
    output logic [DW-1:0] o_den,
    output logic [PW-1:0] o_pass
);

    localparam int CW = (NW > DW + BIT) ? NW + 1 : DW + BIT + 1;

    logic [CW-1:0] w_rem;
    logic [CW-1:0] w_sub;
    logic          w_ge;
    logic [NW-1:0] n_rem;
    logic [QW-1:0] n_quo;
    logic [NW-1:0] r_rem;
    logic [QW-1:0] r_quo;
    logic [DW-1:0] r_den;
    logic [PW-1:0] r_pass;

    // one restoring step for quotient bit BIT
    always_comb begin
        w_rem = CW'(i_rem);
        w_sub = CW'(i_den) << BIT;
        w_ge  = (w_rem >= w_sub);
        if (w_ge) begin
            n_rem = NW'(w_rem - w_sub);
            n_quo = i_quo | (QW'(1) << BIT);
        end else begin
            n_rem = i_rem;
            n_quo = i_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_quo  <= n_quo;
            r_den  <= i_den;
            r_pass <= i_pass;
        end
    end

    assign o_rem  = r_rem;
    assign o_quo  = r_quo;
    assign o_den  = r_den;
    assign o_pass = r_pass;

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 60;

    // idling modes of the stream sides
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;

    typedef struct packed {
        logic [14:0]      volt;
        logic [23:0]      res;
        logic [15:0]      temp;
        ttc_pkg::t_status stat;
    } t_conv;

    typedef struct {
        logic [15:0] word;
        bit          typed;
        t_conv       result;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [55:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [19:0] i_cfg_data;

    // model copy of the configuration
    logic [14:0] m_supply;
    logic [19:0] m_series;
    logic [8:0]  m_ref_temp;
    logic [19:0] m_ref_ohms;
    logic [16:0] m_beta;

    t_conv results_due[$];
    int    mismatches = 0;
    int    idle_mode  = IDLE_NONE;
    int    quiet      = 0;

    thermistor_temperature_convert uut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // log2 with 24 fraction bits, squaring method
    function automatic longint unsigned log2_fix(longint unsigned x);
        int              top;
        longint unsigned m;
        longint unsigned frac;
        top  = 0;
        frac = 0;
        if (x == 0) x = 1;
        for (int i = 63; i >= 0; i--) begin
            if (x[i]) begin
                top = i;
                break;
            end
        end
        m = (top > 31) ? (x >> (top - 31)) : (x << (31 - top));
        for (int i = 0; i < 24; i++) begin
            m    = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                m    = m >> 1;
                frac = frac | 1;
            end
        end
        return (longint'(top) << 24) | frac;
    endfunction

    // divider voltage, resistance and beta-equation temperature of one word
    function automatic t_conv convert(logic [15:0] word);
        longint unsigned v, d, s1, r1, la, lb, mag, res;
        longint          lq, t0c, den, num, tck, tmp, bt;
        t_conv           r;
        v   = longint'(word[15:3]) * 4;
        res = 0;
        tmp = 0;
        if (v >= m_supply) begin
            r.stat = ttc_pkg::STAT_HIGH;
        end else if (v == 0) begin
            r.stat = ttc_pkg::STAT_ZERO;
        end else begin
            r.stat = ttc_pkg::STAT_OK;
            d   = m_supply - v;
            s1  = (m_series == 0) ? 1 : m_series;
            r1  = (m_ref_ohms == 0) ? 1 : m_ref_ohms;
            la  = log2_fix(v * s1);
            lb  = log2_fix(d * r1);
            res = (v * m_series + d / 2) / d;
            if (res > 16777215) res = 16777215;
            mag = (la >= lb) ? la - lb : lb - la;
            mag = (mag * 744261118 + (64'd1 << 29)) >> 30;
            lq  = (la >= lb) ? longint'(mag) : -longint'(mag);
            t0c = longint'($signed(m_ref_temp)) * 100 + 27315;
            bt  = longint'(m_beta) * 10;
            den = lq * t0c + (bt << 24);
            if (den <= 0) begin
                tmp = 32767;
            end else begin
                num = (bt * t0c) << 24;
                tck = (num + den / 2) / den;
                tmp = tck - 27315;
                if (tmp > 32767) tmp = 32767;
                if (tmp < -32768) tmp = -32768;
            end
        end
        r.volt = v[14:0];
        r.res  = res[23:0];
        r.temp = tmp[15:0];
        return r;
    endfunction

    // receiver stalls
    always @(negedge i_clk) begin
        if (idle_mode == IDLE_RECV)
            i_m_axis_tready <= ($urandom_range(99) >= 85);
        else if (idle_mode == IDLE_BOTH)
            i_m_axis_tready <= ($urandom_range(99) >= 21);
        else
            i_m_axis_tready <= 1'b1;
    end

    // result check against the oldest outstanding word
    always @(posedge i_clk) begin
        t_conv got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.volt = o_m_axis_tdata[14:0];
            got.res  = o_m_axis_tdata[38:15];
            got.temp = o_m_axis_tdata[54:39];
            got.stat = ttc_pkg::t_status'(o_m_axis_tuser);
            if (results_due.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word %h / %h", $realtime,
                         o_m_axis_tdata, o_m_axis_tuser);
            end else begin
                want = results_due.pop_front();
                if (got.volt !== want.volt || got.res !== want.res ||
                    got.temp !== want.temp || got.stat !== want.stat) begin
                    mismatches++;
                    $display("%0t: expected volt %0d res %0d temp %0d stat %0d",
                             $realtime, want.volt, want.res, $signed(want.temp),
                             want.stat);
                    $display("%0t:   actual volt %0d res %0d temp %0d stat %0d",
                             $realtime, got.volt, got.res, $signed(got.temp),
                             got.stat);
                end
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet == QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // write one register, entered and left at a falling edge
    task automatic cfg_write(logic [2:0] idx, logic [19:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            ttc_pkg::CFG_SUPPLY:   m_supply   = data[14:0];
            ttc_pkg::CFG_SERIES:   m_series   = data;
            ttc_pkg::CFG_REF_TEMP: m_ref_temp = data[8:0];
            ttc_pkg::CFG_REF_OHMS: m_ref_ohms = data;
            ttc_pkg::CFG_BETA:     m_beta     = data[16:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic cfg_all(logic [19:0] sup, logic [19:0] ser, logic [19:0] rt,
                           logic [19:0] ro, logic [19:0] be);
        cfg_write(ttc_pkg::CFG_SUPPLY, sup);
        cfg_write(ttc_pkg::CFG_SERIES, ser);
        cfg_write(ttc_pkg::CFG_REF_TEMP, rt);
        cfg_write(ttc_pkg::CFG_REF_OHMS, ro);
        cfg_write(ttc_pkg::CFG_BETA, be);
    endtask

    // send one bus word; valid stays high for a following word
    task automatic send_word(logic [15:0] word, bit typed, t_conv result);
        while ((idle_mode == IDLE_SEND && $urandom_range(99) < 85) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < 21)) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = word;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        results_due.push_back(typed ? result : convert(word));
        @(negedge i_clk);
    endtask

    // stop sending and let the pipeline empty
    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    // random word, mostly below the supply so the beta path is exercised
    function automatic logic [15:0] pick_word();
        int unsigned steps;
        steps = m_supply / 4;
        if ($urandom_range(99) < 25 || steps < 2)
            return 16'($urandom_range(16'hFFFF));
        return {13'($urandom_range(steps - 1, 1)), 3'($urandom_range(7))};
    endfunction

    t_row  table_rows[$];
    t_conv blank;

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b1;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        m_supply   = ttc_pkg::RST_SUPPLY;
        m_series   = ttc_pkg::RST_SERIES;
        m_ref_temp = ttc_pkg::RST_REF_TEMP;
        m_ref_ohms = ttc_pkg::RST_REF_OHMS;
        m_beta     = ttc_pkg::RST_BETA;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed words on the reset configuration
        blank = '{volt: 0, res: 0, temp: 0, stat: ttc_pkg::STAT_ZERO};
        table_rows.push_back('{16'h0000, 1, blank});
        table_rows.push_back('{16'h0007, 1, blank});
        table_rows.push_back('{16'hFFFF, 1, '{15'd32764, 0, 0, ttc_pkg::STAT_HIGH}});
        table_rows.push_back('{16'd10288, 1, '{15'd5144, 0, 0, ttc_pkg::STAT_HIGH}});
        table_rows.push_back('{16'd10295, 1, '{15'd5144, 0, 0, ttc_pkg::STAT_HIGH}});
        table_rows.push_back('{16'h8000, 1, '{15'd16384, 0, 0, ttc_pkg::STAT_HIGH}});
        table_rows.push_back('{16'd8, 0, blank});
        table_rows.push_back('{16'd15, 0, blank});
        table_rows.push_back('{16'd10280, 0, blank});
        table_rows.push_back('{16'd5144, 0, blank});
        table_rows.push_back('{16'h5555 & 16'd8191, 0, blank});
        table_rows.push_back('{16'h2AAA & 16'd8191, 0, blank});
        foreach (table_rows[i])
            send_word(table_rows[i].word, table_rows[i].typed, table_rows[i].result);
        drain();

        // configuration phases, extremes first, then random settings
        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: cfg_all(1, 1, 20'hFFFD8, 1, 1000);
                1: cfg_all(32767, 1000000, 150, 1000000, 100000);
                2: cfg_all(20'hF8000 | 5000, 0, 0, 0, 131071);
                3: cfg_all(5144, 1, 20, 1000000, 1000);
                4: cfg_all(0, 3000, 20'h00100, 12110, 34205);
                5: cfg_all(30000, 1000000, 20'hFFF00, 1, 1000);
                default: cfg_all(20'($urandom_range(20'hFFFFF)),
                                 20'($urandom_range(20'hFFFFF)),
                                 20'($urandom_range(20'hFFFFF)),
                                 20'($urandom_range(20'hFFFFF)),
                                 20'($urandom_range(20'hFFFFF)));
            endcase
            // an index past the last register must change nothing
            if (ph == 6) cfg_write(3'($urandom_range(7, 5)), 20'($urandom_range(20'hFFFFF)));
            idle_mode = ph % 4;
            for (int n = 0; n < 64; n++) begin
                if (ph == 7 && n == 32) begin
                    i_s_axis_tvalid = 1'b0;
                    while (results_due.size() != 0) @(negedge i_clk);
                end
                send_word(pick_word(), 0, blank);
            end
            drain();
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* thermistor_temperature_convert.f */
rtl/ttc_pkg.sv
rtl/ttc_log_cell.sv
rtl/ttc_div_cell.sv
rtl/thermistor_temperature_convert.sv
dv/testbench.sv
